// ----- sv/rau_pkg.sv -----
package rau_pkg;

   localparam int OPERAND_BITS_DEF = 16;
   localparam int QUEUE_DEPTH      = 2;

   localparam logic [3:0] OP_ADD = 4'd0;
   localparam logic [3:0] OP_SUB = 4'd1;
   localparam logic [3:0] OP_MUL = 4'd2;
   localparam logic [3:0] OP_DIV = 4'd3;
   localparam logic [3:0] OP_GT  = 4'd4;
   localparam logic [3:0] OP_LT  = 4'd5;
   localparam logic [3:0] OP_GE  = 4'd6;
   localparam logic [3:0] OP_LE  = 4'd7;
   localparam logic [3:0] OP_EQ  = 4'd8;
   localparam logic [3:0] OP_NE  = 4'd9;

   // Tells the back end what to do with a queued item.
   typedef struct packed {
      logic reduce;
      logic cmp;
      logic dz;
   } rau_flags_type;

endpackage

// ----- sv/rational_arith_unit.sv -----
// Channel    Ports                              Beat
// request    req_valid / req_stall, req_*       op code and two fractions
// response   rsp_valid / rsp_stall, rsp_*       reduced fraction and flags
//
// The front end takes a beat, forms the three cross products on one shared
// multiplier and queues the classified item before it takes the next beat.
// The back end sets the rate: a binary GCD of up to 4*OPERAND_BITS steps,
// then 2*OPERAND_BITS steps of restoring division; items that need no
// reduction skip both and go straight to the output.
// Reset is synchronous and clears the control state only.
// A stalled response holds its beat while the front end keeps taking beats
// until the queue between the two ends is full.
module rational_arith_unit #(
   parameter int OPERAND_BITS = rau_pkg::OPERAND_BITS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [3:0]                      req_type,
   input  logic signed [OPERAND_BITS-1:0]  req_left_num,
   input  logic [OPERAND_BITS-2:0]         req_left_den,
   input  logic signed [OPERAND_BITS-1:0]  req_right_num,
   input  logic [OPERAND_BITS-2:0]         req_right_den,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic signed [2*OPERAND_BITS:0]  rsp_result_num,
   output logic [2*OPERAND_BITS-2:0]       rsp_result_den,
   output logic                            rsp_compare_true,
   output logic                            rsp_divide_by_zero
);
   import rau_pkg::*;

   localparam int NB = 2 * OPERAND_BITS + 1;
   localparam int DB = 2 * OPERAND_BITS - 1;
   localparam int FB = $bits(rau_flags_type);
   localparam int QB = FB + NB + DB;

   logic                 push_valid, queue_full, pop, pop_valid;
   logic signed [NB-1:0] f_num, b_num;
   logic [DB-1:0]        f_den, b_den;
   rau_flags_type        f_flags, b_flags;
   logic [QB-1:0]        push_data, pop_data;

   rau_front #(.OPERAND_BITS(OPERAND_BITS)) u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_type      (req_type),
      .req_left_num  (req_left_num),
      .req_left_den  (req_left_den),
      .req_right_num (req_right_num),
      .req_right_den (req_right_den),
      .push_valid    (push_valid),
      .queue_full    (queue_full),
      .item_num      (f_num),
      .item_den      (f_den),
      .item_flags    (f_flags)
   );

   assign push_data = {f_flags, f_num, f_den};

   rau_queue #(.DATA_BITS(QB), .DEPTH(QUEUE_DEPTH)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push_valid),
      .push_data (push_data),
      .full      (queue_full),
      .pop       (pop),
      .pop_valid (pop_valid),
      .pop_data  (pop_data)
   );

   assign b_flags = pop_data[QB-1 -: FB];
   assign b_num   = pop_data[DB +: NB];
   assign b_den   = pop_data[DB-1:0];

   rau_back #(.OPERAND_BITS(OPERAND_BITS)) u_back (
      .clock              (clock),
      .reset              (reset),
      .item_valid         (pop_valid),
      .item_pop           (pop),
      .item_num           (b_num),
      .item_den           (b_den),
      .item_flags         (b_flags),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_result_num     (rsp_result_num),
      .rsp_result_den     (rsp_result_den),
      .rsp_compare_true   (rsp_compare_true),
      .rsp_divide_by_zero (rsp_divide_by_zero)
   );

endmodule

// ----- sv/rau_front.sv -----
module rau_front #(
   parameter int OPERAND_BITS = rau_pkg::OPERAND_BITS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [3:0]                      req_type,
   input  logic signed [OPERAND_BITS-1:0]  req_left_num,
   input  logic [OPERAND_BITS-2:0]         req_left_den,
   input  logic signed [OPERAND_BITS-1:0]  req_right_num,
   input  logic [OPERAND_BITS-2:0]         req_right_den,
   output logic                            push_valid,
   input  logic                            queue_full,
   output logic signed [2*OPERAND_BITS:0]  item_num,
   output logic [2*OPERAND_BITS-2:0]       item_den,
   output rau_pkg::rau_flags_type          item_flags
);
   import rau_pkg::*;

   localparam int W  = OPERAND_BITS;
   localparam int PB = 2 * W;
   localparam int NB = PB + 1;
   localparam int DB = PB - 1;

   localparam logic [2:0] F_IDLE = 3'd0;
   localparam logic [2:0] F_P0   = 3'd1;
   localparam logic [2:0] F_P1   = 3'd2;
   localparam logic [2:0] F_P2   = 3'd3;
   localparam logic [2:0] F_FORM = 3'd4;
   localparam logic [2:0] F_PUSH = 3'd5;

   logic [2:0]           fstate_ff, fstate_in;
   logic [3:0]           op_ff;
   logic signed [W-1:0]  ln_ff, rn_ff;
   logic [W-2:0]         ld_ff, rd_ff;
   logic signed [PB-1:0] p0_ff, p1_ff, p2_ff;
   logic signed [NB-1:0] num_ff, num_in;
   logic [DB-1:0]        den_ff, den_in;
   rau_flags_type        flags_ff, flags_in;

   logic                 take;
   logic signed [W-1:0]  ld_s, rd_s, mul_a, mul_b;
   logic signed [PB-1:0] prod, p1_neg;
   logic signed [NB-1:0] p0x, p1x;

   assign take      = (fstate_ff == F_IDLE) && req_valid;
   assign req_stall = (fstate_ff != F_IDLE);
   assign ld_s      = {1'b0, ld_ff};
   assign rd_s      = {1'b0, rd_ff};

   // One multiplier serves the three products, one per cycle.
   always_comb begin
      mul_a = ln_ff;
      mul_b = rd_s;
      case (fstate_ff)
         F_P0: begin
            mul_a = ln_ff;
            mul_b = (op_ff == OP_MUL) ? rn_ff : rd_s;
         end
         F_P1: begin
            mul_a = rn_ff;
            mul_b = ld_s;
         end
         F_P2: begin
            mul_a = ld_s;
            mul_b = rd_s;
         end
         default: begin
            mul_a = ln_ff;
            mul_b = rd_s;
         end
      endcase
   end

   assign prod   = mul_a * mul_b;
   assign p0x    = {p0_ff[PB-1], p0_ff};
   assign p1x    = {p1_ff[PB-1], p1_ff};
   assign p1_neg = -p1_ff;

   always_comb begin
      num_in   = '0;
      den_in   = DB'(1);
      flags_in = '0;
      case (op_ff)
         OP_ADD: begin
            num_in          = p0x + p1x;
            den_in          = p2_ff[DB-1:0];
            flags_in.reduce = 1'b1;
         end
         OP_SUB: begin
            num_in          = p0x - p1x;
            den_in          = p2_ff[DB-1:0];
            flags_in.reduce = 1'b1;
         end
         OP_MUL: begin
            num_in          = p0x;
            den_in          = p2_ff[DB-1:0];
            flags_in.reduce = 1'b1;
         end
         OP_DIV: begin
            if (rn_ff == '0) begin
               flags_in.dz = 1'b1;
            end else if (p1_ff[PB-1]) begin
               // A negative divisor hands its sign to the numerator.
               num_in          = -p0x;
               den_in          = p1_neg[DB-1:0];
               flags_in.reduce = 1'b1;
            end else begin
               num_in          = p0x;
               den_in          = p1_ff[DB-1:0];
               flags_in.reduce = 1'b1;
            end
         end
         OP_GT: flags_in.cmp = (p0_ff > p1_ff);
         OP_LT: flags_in.cmp = (p0_ff < p1_ff);
         OP_GE: flags_in.cmp = (p0_ff >= p1_ff);
         OP_LE: flags_in.cmp = (p0_ff <= p1_ff);
         OP_EQ: flags_in.cmp = (p0_ff == p1_ff);
         OP_NE: flags_in.cmp = (p0_ff != p1_ff);
         default: begin
            num_in   = '0;
            den_in   = DB'(1);
            flags_in = '0;
         end
      endcase
   end

   always_comb begin
      fstate_in = fstate_ff;
      case (fstate_ff)
         F_IDLE:  if (req_valid) fstate_in = F_P0;
         F_P0:    fstate_in = F_P1;
         F_P1:    fstate_in = F_P2;
         F_P2:    fstate_in = F_FORM;
         F_FORM:  fstate_in = F_PUSH;
         F_PUSH:  if (!queue_full) fstate_in = F_IDLE;
         default: fstate_in = F_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fstate_ff <= F_IDLE;
      end else begin
         fstate_ff <= fstate_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         op_ff <= req_type;
         ln_ff <= req_left_num;
         rn_ff <= req_right_num;
         // A zero denominator counts as one.
         ld_ff <= (req_left_den == '0) ? (W-1)'(1) : req_left_den;
         rd_ff <= (req_right_den == '0) ? (W-1)'(1) : req_right_den;
      end
      if (fstate_ff == F_P0) p0_ff <= prod;
      if (fstate_ff == F_P1) p1_ff <= prod;
      if (fstate_ff == F_P2) p2_ff <= prod;
      if (fstate_ff == F_FORM) begin
         num_ff   <= num_in;
         den_ff   <= den_in;
         flags_ff <= flags_in;
      end
   end

   assign push_valid = (fstate_ff == F_PUSH);
   assign item_num   = num_ff;
   assign item_den   = den_ff;
   assign item_flags = flags_ff;

endmodule

// ----- sv/rau_queue.sv -----
module rau_queue #(
   parameter int DATA_BITS = 8,
   parameter int DEPTH     = rau_pkg::QUEUE_DEPTH
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  logic [DATA_BITS-1:0] push_data,
   output logic                 full,
   input  logic                 pop,
   output logic                 pop_valid,
   output logic [DATA_BITS-1:0] pop_data
);
   import rau_pkg::*;

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [DATA_BITS-1:0] slot_ff [DEPTH];
   logic [PW-1:0]        wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]        count_ff, count_in;
   logic                 do_push, do_pop;

   assign full      = (count_ff == CW'(DEPTH));
   assign pop_valid = (count_ff != '0);
   assign do_push   = push && !full;
   assign do_pop    = pop && pop_valid;
   assign pop_data  = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) slot_ff[wr_ptr_ff] <= push_data;
   end

endmodule

// ----- sv/rau_back.sv -----
module rau_back #(
   parameter int OPERAND_BITS = rau_pkg::OPERAND_BITS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            item_valid,
   output logic                            item_pop,
   input  logic signed [2*OPERAND_BITS:0]  item_num,
   input  logic [2*OPERAND_BITS-2:0]       item_den,
   input  rau_pkg::rau_flags_type          item_flags,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic signed [2*OPERAND_BITS:0]  rsp_result_num,
   output logic [2*OPERAND_BITS-2:0]       rsp_result_den,
   output logic                            rsp_compare_true,
   output logic                            rsp_divide_by_zero
);
   import rau_pkg::*;

   localparam int PB = 2 * OPERAND_BITS;
   localparam int NB = PB + 1;
   localparam int DB = PB - 1;
   localparam int KB = $clog2(PB);

   localparam logic [1:0] B_IDLE = 2'd0;
   localparam logic [1:0] B_GCD  = 2'd1;
   localparam logic [1:0] B_DIV  = 2'd2;
   localparam logic [1:0] B_DONE = 2'd3;

   logic [1:0]           bstate_ff, bstate_in;
   logic [PB-1:0]        ga_ff, ga_in, gb_ff, gb_in;
   logic [PB-1:0]        g_ff, g_in;
   logic [PB-1:0]        mag_ff, mag_in;
   logic [DB-1:0]        den_ff, den_in;
   logic [PB-1:0]        rem_n_ff, rem_n_in, rem_d_ff, rem_d_in;
   logic [KB-1:0]        k_ff, k_in, cnt_ff, cnt_in;
   logic                 neg_ff, neg_in, cmp_ff, cmp_in, dz_ff, dz_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic signed [NB-1:0] rsp_num_ff, rsp_num_in;
   logic [DB-1:0]        rsp_den_ff;
   logic                 rsp_cmp_ff, rsp_dz_ff;

   logic signed [NB-1:0] num_abs, mag_ext;
   logic [PB-1:0]        diff_ab, diff_ba;
   logic [PB:0]          tr_n, tr_d, g_ext;
   logic                 fit_n, fit_d, load_out;

   assign num_abs = item_num[NB-1] ? -item_num : item_num;
   assign diff_ab = ga_ff - gb_ff;
   assign diff_ba = gb_ff - ga_ff;

   // Restoring division of both terms by the common divisor, one bit a cycle.
   assign g_ext = {1'b0, g_ff};
   assign tr_n  = {rem_n_ff, ga_ff[PB-1]};
   assign tr_d  = {rem_d_ff, gb_ff[PB-1]};
   assign fit_n = (tr_n >= g_ext);
   assign fit_d = (tr_d >= g_ext);

   assign load_out = (bstate_ff == B_DONE) && (!rsp_valid_ff || !rsp_stall);
   assign mag_ext  = {1'b0, ga_ff};
   assign rsp_num_in = neg_ff ? -mag_ext : mag_ext;
   assign item_pop = (bstate_ff == B_IDLE) && item_valid;

   always_comb begin
      bstate_in = bstate_ff;
      ga_in     = ga_ff;
      gb_in     = gb_ff;
      g_in      = g_ff;
      mag_in    = mag_ff;
      den_in    = den_ff;
      rem_n_in  = rem_n_ff;
      rem_d_in  = rem_d_ff;
      k_in      = k_ff;
      cnt_in    = cnt_ff;
      neg_in    = neg_ff;
      cmp_in    = cmp_ff;
      dz_in     = dz_ff;
      case (bstate_ff)
         B_IDLE: begin
            if (item_valid) begin
               cmp_in = item_flags.cmp;
               dz_in  = item_flags.dz;
               if (!item_flags.reduce || item_num == '0) begin
                  // Nothing to reduce: the result is 0/1 with the flags.
                  ga_in     = '0;
                  gb_in     = PB'(1);
                  neg_in    = 1'b0;
                  bstate_in = B_DONE;
               end else begin
                  ga_in     = num_abs[PB-1:0];
                  gb_in     = {1'b0, item_den};
                  mag_in    = num_abs[PB-1:0];
                  den_in    = item_den;
                  neg_in    = item_num[NB-1];
                  k_in      = '0;
                  bstate_in = B_GCD;
               end
            end
         end
         B_GCD: begin
            // Binary GCD: one halving or subtract-and-halve a cycle.
            if (ga_ff == gb_ff) begin
               g_in      = ga_ff << k_ff;
               ga_in     = mag_ff;
               gb_in     = {1'b0, den_ff};
               rem_n_in  = '0;
               rem_d_in  = '0;
               cnt_in    = '0;
               bstate_in = B_DIV;
            end else if (!ga_ff[0] && !gb_ff[0]) begin
               ga_in = ga_ff >> 1;
               gb_in = gb_ff >> 1;
               k_in  = k_ff + 1'b1;
            end else if (!ga_ff[0]) begin
               ga_in = ga_ff >> 1;
            end else if (!gb_ff[0]) begin
               gb_in = gb_ff >> 1;
            end else if (ga_ff > gb_ff) begin
               ga_in = diff_ab >> 1;
            end else begin
               gb_in = diff_ba >> 1;
            end
         end
         B_DIV: begin
            rem_n_in = fit_n ? PB'(tr_n - g_ext) : tr_n[PB-1:0];
            rem_d_in = fit_d ? PB'(tr_d - g_ext) : tr_d[PB-1:0];
            ga_in    = {ga_ff[PB-2:0], fit_n};
            gb_in    = {gb_ff[PB-2:0], fit_d};
            cnt_in   = cnt_ff + 1'b1;
            if (cnt_ff == KB'(PB - 1)) bstate_in = B_DONE;
         end
         B_DONE: begin
            if (load_out) bstate_in = B_IDLE;
         end
         default: bstate_in = B_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && !rsp_stall) rsp_valid_in = 1'b0;
      if (load_out) rsp_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bstate_ff    <= B_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         bstate_ff    <= bstate_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ga_ff    <= ga_in;
      gb_ff    <= gb_in;
      g_ff     <= g_in;
      mag_ff   <= mag_in;
      den_ff   <= den_in;
      rem_n_ff <= rem_n_in;
      rem_d_ff <= rem_d_in;
      k_ff     <= k_in;
      cnt_ff   <= cnt_in;
      neg_ff   <= neg_in;
      cmp_ff   <= cmp_in;
      dz_ff    <= dz_in;
      if (load_out) begin
         rsp_num_ff <= rsp_num_in;
         rsp_den_ff <= gb_ff[DB-1:0];
         rsp_cmp_ff <= cmp_ff;
         rsp_dz_ff  <= dz_ff;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_result_num     = rsp_num_ff;
   assign rsp_result_den     = rsp_den_ff;
   assign rsp_compare_true   = rsp_cmp_ff;
   assign rsp_divide_by_zero = rsp_dz_ff;

endmodule

// ----- sv/rau_checker.sv -----
module rau_checker #(
   parameter int OPERAND_BITS = rau_pkg::OPERAND_BITS_DEF
) (
   input logic                            clock,
   input logic                            reset,
   input logic                            rsp_valid,
   input logic                            rsp_stall,
   input logic signed [2*OPERAND_BITS:0]  rsp_result_num,
   input logic [2*OPERAND_BITS-2:0]       rsp_result_den,
   input logic                            rsp_compare_true,
   input logic                            rsp_divide_by_zero
);
   import rau_pkg::*;

   // A stalled response beat stays and keeps its payload.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_result_num)
         && $stable(rsp_result_den) && $stable(rsp_compare_true)
         && $stable(rsp_divide_by_zero))
      else $error("response changed while stalled");

   // A divide by zero reports 0/1 and no comparison.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_divide_by_zero |-> rsp_result_num == '0
         && rsp_result_den == 1 && !rsp_compare_true)
      else $error("divide by zero beat carries a value");

   // A true comparison carries 0/1 and no error.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_compare_true |-> rsp_result_num == '0
         && rsp_result_den == 1 && !rsp_divide_by_zero)
      else $error("comparison beat carries a value");

   // A zero numerator always comes with a denominator of one.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_result_num == '0 |-> rsp_result_den == 1)
      else $error("zero result not normalized");

endmodule

bind rational_arith_unit rau_checker #(.OPERAND_BITS(OPERAND_BITS)) u_rau_checker (.*);

// ----- sim/rational_arith_unit_tb.sv -----
module rational_arith_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import rau_pkg::*;

   localparam int OPERAND_BITS     = OPERAND_BITS_DEF;
   localparam int RANDOM_ITEMS     = 1830;
   localparam int LONG_HOLD_CYCLES = 400;
   localparam int WATCHDOG_LIMIT   = 4000;
   localparam int DRAIN_CYCLES     = 250;

   // Operation codes that the block must answer with a neutral result.
   localparam logic [3:0] OP_UNUSED_LO = 4'd10;
   localparam logic [3:0] OP_UNUSED_HI = 4'd15;

   localparam logic signed [OPERAND_BITS-1:0] NUM_MIN = {1'b1, {(OPERAND_BITS-1){1'b0}}};
   localparam logic signed [OPERAND_BITS-1:0] NUM_MAX = {1'b0, {(OPERAND_BITS-1){1'b1}}};
   localparam logic [OPERAND_BITS-2:0]        DEN_MAX = {(OPERAND_BITS-1){1'b1}};

   typedef struct {
      logic signed [2*OPERAND_BITS:0] num;
      logic [2*OPERAND_BITS-2:0]      den;
      logic                           cmp;
      logic                           dz;
   } fraction_result_type;

   class fraction_scoreboard;
      fraction_result_type expected_fractions[$];
      int mismatch_count;

      function new();
         mismatch_count = 0;
      endfunction

      // Strips the common factor; a zero numerator always becomes 0/1.
      function fraction_result_type reduce_fraction(longint num, longint den);
         fraction_result_type r;
         longint unsigned mag, a, b, t;
         longint q;
         r.cmp = 1'b0;
         r.dz  = 1'b0;
         r.num = '0;
         r.den = 1;
         if (num == 0)
            return r;
         mag = (num < 0) ? -num : num;
         a = mag;
         b = den;
         while (b != 0) begin
            t = a % b;
            a = b;
            b = t;
         end
         q = mag / a;
         r.num = (num < 0) ? -q : q;
         r.den = den / a;
         return r;
      endfunction

      function fraction_result_type predict_fraction(
            logic [3:0] op,
            logic signed [OPERAND_BITS-1:0] ln_in, logic [OPERAND_BITS-2:0] ld_in,
            logic signed [OPERAND_BITS-1:0] rn_in, logic [OPERAND_BITS-2:0] rd_in);
         fraction_result_type r;
         longint ln, ld, rn, rd, lx, rx, num, den;
         ln = ln_in;
         rn = rn_in;
         // A zero denominator is read as one.
         ld = (ld_in == 0) ? 1 : ld_in;
         rd = (rd_in == 0) ? 1 : rd_in;
         lx = ln * rd;
         rx = rn * ld;
         r.num = '0;
         r.den = 1;
         r.cmp = 1'b0;
         r.dz  = 1'b0;
         case (op)
            OP_ADD: r = reduce_fraction(lx + rx, ld * rd);
            OP_SUB: r = reduce_fraction(lx - rx, ld * rd);
            OP_MUL: r = reduce_fraction(ln * rn, ld * rd);
            OP_DIV: begin
               if (rn == 0) begin
                  r.dz = 1'b1;
               end else begin
                  num = ln * rd;
                  den = ld * rn;
                  // The divisor's sign moves to the numerator.
                  if (den < 0) begin
                     den = -den;
                     num = -num;
                  end
                  r = reduce_fraction(num, den);
               end
            end
            OP_GT: r.cmp = (lx > rx);
            OP_LT: r.cmp = (lx < rx);
            OP_GE: r.cmp = (lx >= rx);
            OP_LE: r.cmp = (lx <= rx);
            OP_EQ: r.cmp = (lx == rx);
            OP_NE: r.cmp = (lx != rx);
            default: ;
         endcase
         return r;
      endfunction

      function void note_request(
            logic [3:0] op,
            logic signed [OPERAND_BITS-1:0] ln, logic [OPERAND_BITS-2:0] ld,
            logic signed [OPERAND_BITS-1:0] rn, logic [OPERAND_BITS-2:0] rd);
         expected_fractions.push_back(predict_fraction(op, ln, ld, rn, rd));
      endfunction

      function void check_result(logic signed [2*OPERAND_BITS:0] num,
                                 logic [2*OPERAND_BITS-2:0] den,
                                 logic cmp, logic dz);
         fraction_result_type e;
         if (expected_fractions.size() == 0) begin
            $display("%0t: unexpected response beat num %0d den %0d cmp %0b dz %0b",
                     $time, num, den, cmp, dz);
            mismatch_count++;
            return;
         end
         e = expected_fractions.pop_front();
         if (num !== e.num) begin
            $display("%0t: rsp_result_num expected %0d got %0d", $time, e.num, num);
            mismatch_count++;
         end
         if (den !== e.den) begin
            $display("%0t: rsp_result_den expected %0d got %0d", $time, e.den, den);
            mismatch_count++;
         end
         if (cmp !== e.cmp) begin
            $display("%0t: rsp_compare_true expected %0b got %0b", $time, e.cmp, cmp);
            mismatch_count++;
         end
         if (dz !== e.dz) begin
            $display("%0t: rsp_divide_by_zero expected %0b got %0b", $time, e.dz, dz);
            mismatch_count++;
         end
      endfunction

      function int outstanding();
         return expected_fractions.size();
      endfunction
   endclass

   logic                           clock;
   logic                           reset;
   logic                           req_valid;
   logic                           req_stall;
   logic [3:0]                     req_type;
   logic signed [OPERAND_BITS-1:0] req_left_num;
   logic [OPERAND_BITS-2:0]        req_left_den;
   logic signed [OPERAND_BITS-1:0] req_right_num;
   logic [OPERAND_BITS-2:0]        req_right_den;
   logic                           rsp_valid;
   logic                           rsp_stall;
   logic signed [2*OPERAND_BITS:0] rsp_result_num;
   logic [2*OPERAND_BITS-2:0]      rsp_result_den;
   logic                           rsp_compare_true;
   logic                           rsp_divide_by_zero;

   fraction_scoreboard sb;
   bit hold_rsp_request = 1'b0;
   int idle_cycles;

   rational_arith_unit #(.OPERAND_BITS(OPERAND_BITS)) uut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_type           (req_type),
      .req_left_num       (req_left_num),
      .req_left_den       (req_left_den),
      .req_right_num      (req_right_num),
      .req_right_den      (req_right_den),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_result_num     (rsp_result_num),
      .rsp_result_den     (rsp_result_den),
      .rsp_compare_true   (rsp_compare_true),
      .rsp_divide_by_zero (rsp_divide_by_zero)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // Mostly short gaps, now and then a long one.
   function automatic int pick_gap();
      int sel;
      sel = $urandom_range(0, 99);
      if (sel < 50) return 0;
      if (sel < 85) return $urandom_range(1, 3);
      if (sel < 97) return $urandom_range(4, 20);
      return $urandom_range(30, 150);
   endfunction

   function automatic logic signed [OPERAND_BITS-1:0] pick_numerator();
      int sel;
      sel = $urandom_range(0, 9);
      if (sel < 4) return OPERAND_BITS'($urandom);
      if (sel < 7) return OPERAND_BITS'($urandom_range(0, 40) - 20);
      case ($urandom_range(0, 4))
         0: return NUM_MIN;
         1: return NUM_MAX;
         2: return -1;
         3: return 0;
         default: return 1;
      endcase
   endfunction

   function automatic logic [OPERAND_BITS-2:0] pick_denominator();
      int sel;
      sel = $urandom_range(0, 9);
      if (sel < 5) return (OPERAND_BITS-1)'($urandom);
      if (sel < 8) return (OPERAND_BITS-1)'($urandom_range(0, 12));
      case ($urandom_range(0, 3))
         0: return 0;
         1: return 1;
         2: return DEN_MAX;
         default: return {1'b1, {(OPERAND_BITS-2){1'b0}}};
      endcase
   endfunction

   // Offers one beat, waits for it to be taken, then idles for gap cycles.
   task automatic send_request(logic [3:0] op,
                               logic signed [OPERAND_BITS-1:0] ln,
                               logic [OPERAND_BITS-2:0] ld,
                               logic signed [OPERAND_BITS-1:0] rn,
                               logic [OPERAND_BITS-2:0] rd,
                               int gap);
      req_valid     <= 1'b1;
      req_type      <= op;
      req_left_num  <= ln;
      req_left_den  <= ld;
      req_right_num <= rn;
      req_right_den <= rd;
      do @(posedge clock); while (req_stall);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic wait_for_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (sb.outstanding() != 0);
   endtask

   // Beat monitor and watchdog.
   always @(posedge clock) begin
      if (reset) begin
         idle_cycles <= 0;
      end else begin
         if (req_valid && !req_stall)
            sb.note_request(req_type, req_left_num, req_left_den,
                            req_right_num, req_right_den);
         if (rsp_valid && !rsp_stall)
            sb.check_result(rsp_result_num, rsp_result_den,
                            rsp_compare_true, rsp_divide_by_zero);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
            idle_cycles <= 0;
         end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL");
            $finish;
         end else begin
            idle_cycles <= idle_cycles + 1;
         end
      end
   end

   // Response side: random stalls, quiet stretches, and one long hold on request.
   initial begin : response_driver
      int ready_len;
      int stall_len;
      rsp_stall <= 1'b0;
      wait (reset == 1'b0);
      @(posedge clock);
      forever begin
         if (hold_rsp_request) begin
            hold_rsp_request = 1'b0;
            rsp_stall <= 1'b1;
            repeat (LONG_HOLD_CYCLES) @(posedge clock);
         end
         ready_len = ($urandom_range(0, 15) == 0) ? $urandom_range(50, 150)
                                                  : $urandom_range(1, 8);
         rsp_stall <= 1'b0;
         repeat (ready_len) @(posedge clock);
         stall_len = pick_gap();
         if (stall_len > 0) begin
            rsp_stall <= 1'b1;
            repeat (stall_len) @(posedge clock);
         end
      end
   end

   initial begin : request_driver
      int i;
      int gap;
      int burst_left;
      bit pause;
      logic [3:0] op;
      logic signed [OPERAND_BITS-1:0] ln, rn;
      logic [OPERAND_BITS-2:0] ld, rd;
      sb = new();
      burst_left = 0;
      reset         <= 1'b1;
      req_valid     <= 1'b0;
      req_type      <= OP_ADD;
      req_left_num  <= '0;
      req_left_den  <= 1;
      req_right_num <= '0;
      req_right_den <= 1;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_request(OP_ADD, NUM_MAX, 1, NUM_MAX, 1, pick_gap());
      send_request(OP_ADD, NUM_MIN, 0, NUM_MIN, 0, pick_gap());
      send_request(OP_ADD, NUM_MAX, DEN_MAX, NUM_MIN, DEN_MAX - 1'b1, pick_gap());
      send_request(OP_ADD, 5, 7, -5, 7, pick_gap());
      send_request(OP_ADD, 3, 0, 1, 0, pick_gap());
      send_request(OP_SUB, NUM_MAX, DEN_MAX, NUM_MIN, DEN_MAX - 1'b1, pick_gap());
      send_request(OP_SUB, NUM_MAX, 1, NUM_MIN, 1, pick_gap());
      send_request(OP_SUB, 1, 3, 1, 3, pick_gap());
      send_request(OP_MUL, NUM_MIN, 1, NUM_MIN, 1, pick_gap());
      send_request(OP_MUL, NUM_MAX, DEN_MAX - 1'b1, NUM_MIN, DEN_MAX, pick_gap());
      send_request(OP_MUL, 0, 5, 123, 4, pick_gap());
      send_request(OP_DIV, 7, 3, 0, 5, pick_gap());
      send_request(OP_DIV, 3, 4, -5, 6, pick_gap());
      send_request(OP_DIV, NUM_MIN, DEN_MAX, NUM_MIN, 1, pick_gap());
      send_request(OP_DIV, NUM_MAX, 1, -1, DEN_MAX, pick_gap());
      send_request(OP_DIV, 0, 9, 5, 2, pick_gap());
      send_request(OP_GT, 1, 2, 1, 3, pick_gap());
      send_request(OP_GT, NUM_MIN, 1, NUM_MAX, 1, pick_gap());
      send_request(OP_LT, -1, 2, 1, 3, pick_gap());
      send_request(OP_GE, 2, 4, 1, 2, pick_gap());
      send_request(OP_LE, 7, 3, 2, 1, pick_gap());
      send_request(OP_EQ, 1, 2, 2, 4, pick_gap());
      send_request(OP_NE, 1, 2, 2, 4, pick_gap());
      send_request(OP_UNUSED_LO, 9, 2, 4, 3, pick_gap());
      send_request(OP_UNUSED_HI, NUM_MIN, DEN_MAX, NUM_MAX, 0, pick_gap());

      for (i = 0; i < RANDOM_ITEMS; i++) begin
         op = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI))
                                           : 4'($urandom_range(OP_ADD, OP_NE));
         ln = pick_numerator();
         ld = pick_denominator();
         rn = pick_numerator();
         rd = pick_denominator();
         // Equal operands make the equality comparisons and zero differences likely.
         if ($urandom_range(0, 99) < 15) begin
            rn = ln;
            rd = ld;
         end
         // Fill the block: the receiver holds off while beats keep coming.
         if (i == 200) begin
            hold_rsp_request = 1'b1;
            burst_left = 24;
         end
         if (burst_left > 0) begin
            burst_left--;
            gap = 0;
         end else begin
            gap = pick_gap();
            if ($urandom_range(0, 19) == 0)
               burst_left = $urandom_range(10, 40);
         end
         pause = (i % 450 == 449) || (i == RANDOM_ITEMS - 1);
         if (pause)
            gap = 0;
         send_request(op, ln, ld, rn, rd, gap);
         if (pause)
            wait_for_results();
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.mismatch_count == 0 && sb.outstanding() == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule

// ----- files.f -----
sv/rau_pkg.sv
sv/rau_front.sv
sv/rau_queue.sv
sv/rau_back.sv
sv/rational_arith_unit.sv
sv/rau_checker.sv
sim/rational_arith_unit_tb.sv
